### hw/rtl/avsc_pkg.sv
// ----------------------------------------------------------------------------
// avsc_pkg
// Shared widths, constants and register codes for the A/V sync sample-count
// corrector.
// ----------------------------------------------------------------------------
package avsc_pkg;

	localparam int COEF_BITS = 16;                  // avg_coef fraction bits
	localparam int SUM_W     = 48;
	localparam int DIFF_W    = 32;
	localparam int N_W       = 16;
	localparam int OUT_W     = 17;
	localparam int CNT_W     = 8;
	localparam int THR_W     = 31;
	localparam int RATE_W    = 18;
	localparam int WGT_W     = COEF_BITS + 1;       // 2^16 - coef needs 17 bits
	localparam int PSUM_W    = 64;                  // sum * weight product
	localparam int PCORR_W   = DIFF_W + RATE_W;     // diff * rate product
	localparam int LIM_W     = 23;                  // n * 110 fits here
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int IN_DATA_W = 48;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 24;

	localparam int PCT_BASE = 100;
	localparam int PCT_LO   = 90;
	localparam int PCT_HI   = 110;

	localparam logic [OUT_W-1:0] OUT_MAX = 17'd72088;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [COEF_BITS-1:0] RST_AVG_COEF = 16'd52034;
	localparam logic [THR_W-1:0]     RST_AVG_THR  = 31'd1522;
	localparam logic [THR_W-1:0]     RST_NOSYNC   = 31'd655360;
	localparam logic [CNT_W-1:0]     RST_WARMUP   = 8'd20;
	localparam logic [RATE_W-1:0]    RST_RATE     = 18'd44100;

	typedef enum logic [2:0] {
		REG_AVG_COEF    = 3'd0,
		REG_AVG_THR     = 3'd1,
		REG_NOSYNC_THR  = 3'd2,
		REG_WARMUP      = 3'd3,
		REG_SAMPLE_RATE = 3'd4
	} reg_idx_t;

endpackage

### hw/rtl/avsc_ser_mul.sv
// ----------------------------------------------------------------------------
// avsc_ser_mul
// Bit-serial multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module avsc_ser_mul #(
	parameter int AW = 48,
	parameter int BW = 17,
	parameter int PW = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic                 busy,
	output logic signed [PW-1:0] p
);

	localparam int CW = $clog2(BW + 1);

	logic signed [PW-1:0] a_q;
	logic signed [PW-1:0] acc_q;
	logic [BW-1:0]        b_q;
	logic [CW-1:0]        cnt_q;
	logic signed [PW-1:0] addend;

	assign addend = b_q[BW-1] ? a_q : {PW{1'b0}};
	assign busy   = (cnt_q != '0);
	assign p      = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy) begin
			acc_q <= (acc_q <<< 1) + addend;
			b_q   <= b_q << 1;
		end
	end

endmodule

### hw/rtl/avsc_const_div.sv
// ----------------------------------------------------------------------------
// avsc_const_div
// Restoring divider by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avsc_const_div #(
	parameter int XW      = 23,
	parameter int DIVISOR = 100
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	output logic          busy,
	output logic [XW-1:0] q
);

	localparam int RW = $clog2(DIVISOR);
	localparam int CW = $clog2(XW + 1);
	localparam logic [RW:0] DIV_C = (RW+1)'(DIVISOR);

	logic [XW-1:0] x_q;
	logic [XW-1:0] q_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [RW:0]   trial;
	logic          ge;
	logic [RW:0]   diff;

	assign trial = {rem_q, x_q[XW-1]};
	assign ge    = (trial >= DIV_C);
	assign diff  = trial - DIV_C;
	assign busy  = (cnt_q != '0);
	assign q     = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(XW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			q_q   <= '0;
			rem_q <= '0;
		end else if (busy) begin
			x_q   <= x_q << 1;
			q_q   <= {q_q[XW-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

endmodule

### hw/rtl/av_sync_sample_count_corrector.sv
// ----------------------------------------------------------------------------
// av_sync_sample_count_corrector
// Corrects the per-frame audio sample count from a smoothed audio-minus-master
// clock difference, clipped to 90%..110% of the frame's count.
// ----------------------------------------------------------------------------
// Path from acceptance to m_tvalid: master, invalid or out-of-range words go
// straight to S_DONE; warm-up words pass S_RUN1 and S_UPD; words whose average is
// checked go on through S_AVGST, S_RUN2, S_AVG and S_CHK. The bit-serial divides
// by 100 and the serial multipliers set how long S_RUN1 and S_RUN2 last. One word
// in flight at a time; the next word can be taken in the cycle the result is presented.
// Reset: registers to defaults, weighted sum and warm-up counter to zero.
// ----------------------------------------------------------------------------
module av_sync_sample_count_corrector #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// stream in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [avsc_pkg::IN_DATA_W-1:0]  s_tdata,  // clock_diff[31:0], frame_samples[47:32]
	input  logic [avsc_pkg::IN_USER_W-1:0]  s_tuser,  // audio_is_master[0], diff_valid[1]
	// stream out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [avsc_pkg::OUT_DATA_W-1:0] m_tdata,  // wanted_samples[16:0], zero pad
	// config
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [avsc_pkg::ADDR_W-1:0]     paddr,
	input  logic [avsc_pkg::DATA_W-1:0]     pwdata,
	output logic [avsc_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	import avsc_pkg::*;

	localparam int CORR_W = PCORR_W - FRAC_BITS;
	localparam int CAND_W = CORR_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN1,
		S_UPD,
		S_AVGST,
		S_RUN2,
		S_AVG,
		S_CHK,
		S_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [COEF_BITS-1:0] coef_q;
	logic [THR_W-1:0]     avg_thr_q;
	logic [THR_W-1:0]     nosync_q;
	logic [CNT_W-1:0]     warmup_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= RST_AVG_COEF;
			avg_thr_q <= RST_AVG_THR;
			nosync_q  <= RST_NOSYNC;
			warmup_q  <= RST_WARMUP;
			rate_q    <= RST_RATE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_AVG_COEF:    coef_q    <= pwdata[COEF_BITS-1:0];
				REG_AVG_THR:     avg_thr_q <= pwdata[THR_W-1:0];
				REG_NOSYNC_THR:  nosync_q  <= pwdata[THR_W-1:0];
				REG_WARMUP:      warmup_q  <= pwdata[CNT_W-1:0];
				REG_SAMPLE_RATE: rate_q    <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_AVG_COEF:    prdata = DATA_W'(coef_q);
			REG_AVG_THR:     prdata = DATA_W'(avg_thr_q);
			REG_NOSYNC_THR:  prdata = DATA_W'(nosync_q);
			REG_WARMUP:      prdata = DATA_W'(warmup_q);
			REG_SAMPLE_RATE: prdata = DATA_W'(rate_q);
			default:         prdata = '0;
		endcase
	end

	// input word fields
	logic                     in_acc;
	logic                     in_master;
	logic                     in_dvalid;
	logic signed [DIFF_W-1:0] in_diff;
	logic [N_W-1:0]           in_n;
	logic [DIFF_W-1:0]        in_mag;
	logic                     go;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign in_master = s_tuser[0];
	assign in_dvalid = s_tuser[1];
	assign in_diff   = s_tdata[DIFF_W-1:0];
	assign in_n      = s_tdata[DIFF_W +: N_W];
	// |-2^31| = 2^31 still fits the unsigned magnitude
	assign in_mag    = in_diff[DIFF_W-1] ? (~in_diff + 1'b1) : in_diff;
	assign go        = in_acc & ~in_master & in_dvalid & (in_mag < {1'b0, nosync_q});

	// state
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [N_W-1:0]           n_q;
	logic signed [CORR_W-1:0] corr_q;
	logic signed [CAND_W-1:0] cand_q;
	logic signed [SUM_W-1:0]  avg_q;
	logic [OUT_W-1:0]         wanted_q;
	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_data_q;

	// shared serial multiplier: coef * sum, then (2^16 - coef) * sum
	logic                     mul_start;
	logic [WGT_W-1:0]         mul_b;
	logic                     mul_busy;
	logic signed [PSUM_W-1:0] mul_p;

	assign mul_start = go | (state_q == S_AVGST);
	assign mul_b     = (state_q == S_AVGST) ? (WGT_W'(1 << COEF_BITS) - {1'b0, coef_q})
	                                        : {1'b0, coef_q};

	avsc_ser_mul #(.AW(SUM_W), .BW(WGT_W), .PW(PSUM_W)) u_sum_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sum_q),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	logic                      cmul_busy;
	logic signed [PCORR_W-1:0] cmul_p;

	avsc_ser_mul #(.AW(DIFF_W), .BW(RATE_W), .PW(PCORR_W)) u_corr_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go),
		.a      (in_diff),
		.b      (rate_q),
		.busy   (cmul_busy),
		.p      (cmul_p)
	);

	logic [LIM_W-1:0] lo_x, hi_x, lo_q, hi_q;
	logic             lo_busy, hi_busy;

	assign lo_x = LIM_W'(in_n) * LIM_W'(PCT_LO);
	assign hi_x = LIM_W'(in_n) * LIM_W'(PCT_HI);

	avsc_const_div #(.XW(LIM_W), .DIVISOR(PCT_BASE)) u_lo_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go),
		.x      (lo_x),
		.busy   (lo_busy),
		.q      (lo_q)
	);

	avsc_const_div #(.XW(LIM_W), .DIVISOR(PCT_BASE)) u_hi_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go),
		.x      (hi_x),
		.busy   (hi_busy),
		.q      (hi_q)
	);

	logic any_busy;
	assign any_busy = mul_busy | cmul_busy | lo_busy | hi_busy;

	// sum update: round half up, add diff, saturate to 48 bits
	logic signed [PSUM_W-1:0] p_rnd;
	logic [SUM_W-1:0]         p_sh;
	logic signed [SUM_W:0]    s_ext;
	logic signed [SUM_W-1:0]  s_sat;

	assign p_rnd = mul_p + PSUM_W'(1 << (COEF_BITS - 1));
	assign p_sh  = p_rnd[COEF_BITS +: SUM_W];
	assign s_ext = $signed({p_sh[SUM_W-1], p_sh})
	             + $signed({{(SUM_W+1-DIFF_W){diff_q[DIFF_W-1]}}, diff_q});

	always_comb begin
		if (s_ext[SUM_W] != s_ext[SUM_W-1]) begin
			s_sat = s_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			s_sat = s_ext[SUM_W-1:0];
		end
	end

	// correction: truncate toward zero by biasing negatives
	logic [PCORR_W-1:0] corr_full;
	assign corr_full = cmul_p
	                 + {{(PCORR_W-FRAC_BITS){1'b0}}, {FRAC_BITS{cmul_p[PCORR_W-1]}}};

	// average check and clamp
	logic [SUM_W-1:0]         avg_mag;
	logic signed [CAND_W-1:0] lo_s, hi_s;
	logic [OUT_W-1:0]         clamped;

	assign avg_mag = avg_q[SUM_W-1] ? (~avg_q + 1'b1) : avg_q;
	assign lo_s    = $signed(CAND_W'(lo_q[OUT_W-1:0]));
	assign hi_s    = $signed(CAND_W'(hi_q[OUT_W-1:0]));

	always_comb begin
		if (cand_q < lo_s) begin
			clamped = lo_q[OUT_W-1:0];
		end else if (cand_q > hi_s) begin
			clamped = hi_q[OUT_W-1:0];
		end else begin
			clamped = cand_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sum_q      <= '0;
			cnt_q      <= '0;
			diff_q     <= '0;
			n_q        <= '0;
			corr_q     <= '0;
			cand_q     <= '0;
			avg_q      <= '0;
			wanted_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			// S_DONE reloads the output slot itself when it frees up
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						diff_q   <= in_diff;
						n_q      <= in_n;
						wanted_q <= in_n;
						if (go) begin
							state_q <= S_RUN1;
						end else begin
							if (!in_master) begin
								sum_q <= '0;
								cnt_q <= '0;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_RUN1: begin
					if (!any_busy) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sum_q  <= s_sat;
					corr_q <= corr_full[FRAC_BITS +: CORR_W];
					if (cnt_q < warmup_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_AVGST;
					end
				end
				S_AVGST: begin
					cand_q  <= CAND_W'(corr_q) + $signed(CAND_W'(n_q));
					state_q <= S_RUN2;
				end
				S_RUN2: begin
					if (!mul_busy) begin
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					avg_q   <= p_sh;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (avg_mag >= {{(SUM_W-THR_W){1'b0}}, avg_thr_q}) begin
						wanted_q <= clamped;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= wanted_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(m_data_q);

	// serial units only run inside the two compute phases
	a_units_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		any_busy |-> (state_q == S_RUN1 || state_q == S_RUN2))
		else $error("serial unit busy outside a compute phase");

	// clamp and pass-through keep the count within 110% of a full frame
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:0] <= OUT_MAX))
		else $error("wanted_samples out of range");

	// a master-mode word leaves the averaging state alone
	a_master_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_master) |=> ($stable(sum_q) && $stable(cnt_q)))
		else $error("master word changed averaging state");

endmodule
